>>> rtl/gga_pkg.sv
// gga_pkg: shared types and constants for the GBK glyph address stream.
// Used by gga_front, gga_fifo, gga_back and gbk_glyph_address_stream.
package gga_pkg;

    typedef enum logic [1:0] {
        KIND_HALF    = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_MISSING = 2'd2,
        KIND_NEWLINE = 2'd3
    } kind_t;

    localparam int BASE_W  = 24;
    localparam int SIZE_W  = 7;
    localparam int CODE_W  = 7;
    localparam int IDX_W   = 15;
    localparam int BYTES_W = 10;
    localparam int WIDTH_W = 7;
    localparam int PROD_W  = IDX_W + BYTES_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ASCII_BASE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CJK_BASE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_SIZE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ASCII_FIRST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_KIND  = 3'd4;

    localparam logic [BASE_W-1:0] RST_ASCII_BASE  = '0;
    localparam logic [BASE_W-1:0] RST_CJK_BASE    = '0;
    localparam logic [SIZE_W-1:0] RST_GLYPH_SIZE  = 7'd16;
    localparam logic [CODE_W-1:0] RST_ASCII_FIRST = 7'd32;
    localparam logic              RST_INDEX_KIND  = 1'b1;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] HALF_MIN      = 8'h20;
    localparam logic [7:0] HALF_MAX      = 8'h7F;
    localparam logic [7:0] LEAD_MIN      = 8'h81;
    localparam logic [7:0] LEAD_MAX      = 8'hFE;
    localparam logic [7:0] TRAIL_MIN     = 8'h40;
    localparam logic [7:0] TRAIL_MAX     = 8'hFE;
    localparam logic [7:0] TRAIL_GAP     = 8'h7F;
    localparam logic [7:0] TRAIL_SPLIT   = 8'h80;
    localparam logic [7:0] TRAIL_HI_BASE = 8'h41;
    localparam logic [7:0] GB_FIRST      = 8'hA1;

    localparam logic [IDX_W-1:0] GB_ROW  = 15'd94;
    localparam logic [IDX_W-1:0] GBK_ROW = 15'd190;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 7'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [BASE_W-1:0] ascii_unit_base;
        logic [BASE_W-1:0] cjk_unit_base;
        logic [SIZE_W-1:0] glyph_size;
        logic [CODE_W-1:0] ascii_first_code;
        logic              index_kind;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic [BYTES_W-1:0] bytes;
        logic [WIDTH_W-1:0] width;
    } item_t;

endpackage

>>> rtl/gga_front.sv
// gga_front: accepts text bytes, pairs lead/trail bytes and classifies glyphs.
// Depends on gga_pkg; feeds gga_fifo.
module gga_front
    import gga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_value_reg;
    logic [7:0] lead_value_next;

    logic              accept;
    logic              trail_ok;
    logic              lead_ok;
    logic [SIZE_W-1:0] size_c;
    logic [SIZE_W-1:0] half_w;
    logic [SIZE_W:0]   full_sum;
    logic [SIZE_W:0]   half_sum;
    logic [3:0]        full_rows;
    logic [3:0]        half_rows;
    logic [10:0]       full_prod;
    logic [10:0]       half_prod;
    logic [7:0]        gb_hi;
    logic [7:0]        gb_lo;
    logic [7:0]        gbk_hi;
    logic [7:0]        gbk_lo;
    logic [7:0]        half_off;
    logic [IDX_W-1:0]  gb_idx;
    logic [IDX_W-1:0]  gbk_idx;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign trail_ok = (text_byte >= TRAIL_MIN) && (text_byte <= TRAIL_MAX)
                      && (text_byte != TRAIL_GAP);
    assign lead_ok  = (text_byte >= LEAD_MIN) && (text_byte <= LEAD_MAX);

    always_comb
    begin
        if (cfg.glyph_size < SIZE_MIN)
        begin
            size_c = SIZE_MIN;
        end
        else if (cfg.glyph_size > SIZE_MAX)
        begin
            size_c = SIZE_MAX;
        end
        else
        begin
            size_c = cfg.glyph_size;
        end
    end

    assign half_w    = size_c >> 1;
    assign full_sum  = {1'b0, size_c} + 8'd7;
    assign half_sum  = {1'b0, half_w} + 8'd7;
    assign full_rows = full_sum[6:3];
    assign half_rows = half_sum[6:3];
    assign full_prod = {4'b0, size_c} * {7'b0, full_rows};
    assign half_prod = {4'b0, size_c} * {7'b0, half_rows};

    assign gb_hi    = lead_value_reg - GB_FIRST;
    assign gb_lo    = text_byte - GB_FIRST;
    assign gbk_hi   = lead_value_reg - LEAD_MIN;
    assign gbk_lo   = (text_byte >= TRAIL_SPLIT) ? (text_byte - TRAIL_HI_BASE)
                                                 : (text_byte - TRAIL_MIN);
    assign half_off = text_byte - {1'b0, cfg.ascii_first_code};
    assign gb_idx   = ({8'b0, gb_hi[6:0]} * GB_ROW) + {7'b0, gb_lo};
    assign gbk_idx  = ({8'b0, gbk_hi[6:0]} * GBK_ROW) + {7'b0, gbk_lo};

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_value_next   = lead_value_reg;
        q_push            = 1'b0;
        q_item.kind       = KIND_NEWLINE;
        q_item.idx        = '0;
        q_item.bytes      = '0;
        q_item.width      = '0;
        if (accept)
        begin
            lead_pending_next = 1'b0;
            lead_value_next   = '0;
            if (lead_pending_reg && trail_ok)
            begin
                q_push       = 1'b1;
                q_item.width = size_c;
                if (!cfg.index_kind)
                begin
                    if ((lead_value_reg < GB_FIRST) || (text_byte < GB_FIRST))
                    begin
                        q_item.kind = KIND_MISSING;
                    end
                    else
                    begin
                        q_item.kind  = KIND_FULL;
                        q_item.idx   = gb_idx;
                        q_item.bytes = full_prod[BYTES_W-1:0];
                    end
                end
                else
                begin
                    q_item.kind  = KIND_FULL;
                    q_item.idx   = gbk_idx;
                    q_item.bytes = full_prod[BYTES_W-1:0];
                end
            end
            else if (text_byte == CH_NEWLINE)
            begin
                q_push = 1'b1;
            end
            else if ((text_byte >= HALF_MIN) && (text_byte <= HALF_MAX))
            begin
                q_push       = 1'b1;
                q_item.width = half_w;
                if (text_byte[6:0] < cfg.ascii_first_code)
                begin
                    q_item.kind = KIND_MISSING;
                end
                else
                begin
                    q_item.kind  = KIND_HALF;
                    q_item.idx   = {7'b0, half_off};
                    q_item.bytes = half_prod[BYTES_W-1:0];
                end
            end
            else if (lead_ok && !last_byte)
            begin
                lead_pending_next = 1'b1;
                lead_value_next   = text_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_value_reg   <= '0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_value_reg   <= lead_value_next;
        end
    end

    a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
        lead_pending_reg |-> (lead_value_reg >= LEAD_MIN) && (lead_value_reg <= LEAD_MAX))
        else $error("held lead byte out of lead range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> !lead_pending_reg)
        else $error("lead kept past last byte");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> accept)
        else $error("queue push without an accepted byte");

endmodule

>>> rtl/gga_fifo.sv
// gga_fifo: short register queue of classified glyph items.
// Depends on gga_pkg; sits between gga_front and gga_back.
module gga_fifo
    import gga_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t pop_item
);

    item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> full)
        else $error("queue lost fill state on blocked push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

>>> rtl/gga_back.sv
// gga_back: turns classified items into flash fetch requests.
// Depends on gga_pkg; multiply stage then base add into the output register.
module gga_back
    import gga_pkg::*;
#(
    parameter int ADDR_BITS = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           glyph_kind,
    output logic [ADDR_BITS-1:0] glyph_addr,
    output logic [9:0]           glyph_bytes,
    output logic [6:0]           glyph_width
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    kind_t              s1_kind_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [BYTES_W-1:0] s1_bytes_reg;
    logic [WIDTH_W-1:0] s1_width_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    kind_t                out_kind_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [BYTES_W-1:0]   out_bytes_reg;
    logic [WIDTH_W-1:0]   out_width_reg;

    logic                        out_take;
    logic                        s1_ready;
    logic [BASE_W-1:0]           base_sel;
    logic [SUM_W-1:0]            addr_sum;
    logic [SUM_W+ADDR_BITS-1:0]  addr_ext;
    logic [ADDR_BITS-1:0]        addr_next;

    assign out_take = !out_valid_reg || pop;
    assign s1_ready = !s1_valid_reg || out_take;
    assign q_pop    = q_valid && s1_ready;

    assign s1_valid_next  = s1_ready ? q_valid : s1_valid_reg;
    assign out_valid_next = out_take ? s1_valid_reg : out_valid_reg;

    assign base_sel = (s1_kind_reg == KIND_HALF) ? cfg.ascii_unit_base : cfg.cjk_unit_base;
    assign addr_sum = {2'b0, base_sel} + {1'b0, s1_prod_reg};
    assign addr_ext = {{ADDR_BITS{1'b0}}, addr_sum};

    always_comb
    begin
        if ((s1_kind_reg == KIND_HALF) || (s1_kind_reg == KIND_FULL))
        begin
            addr_next = addr_ext[ADDR_BITS-1:0];
        end
        else
        begin
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_kind_reg  <= q_item.kind;
            s1_prod_reg  <= {{BYTES_W{1'b0}}, q_item.idx} * {{IDX_W{1'b0}}, q_item.bytes};
            s1_bytes_reg <= q_item.bytes;
            s1_width_reg <= q_item.width;
        end
        if (out_take)
        begin
            out_kind_reg  <= s1_kind_reg;
            out_addr_reg  <= addr_next;
            out_bytes_reg <= s1_bytes_reg;
            out_width_reg <= s1_width_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign glyph_kind  = out_kind_reg;
    assign glyph_addr  = out_addr_reg;
    assign glyph_bytes = out_bytes_reg;
    assign glyph_width = out_width_reg;

    a_no_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_kind_reg == KIND_MISSING) || (out_kind_reg == KIND_NEWLINE)))
        |-> (out_addr_reg == '0) && (out_bytes_reg == '0))
        else $error("fetch fields set on missing or newline result");

    a_newline_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_NEWLINE)) |-> (out_width_reg == '0))
        else $error("newline with nonzero width");

    a_half_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_HALF))
        |-> (out_width_reg <= 7'd32) && (out_bytes_reg <= 10'd256))
        else $error("half-width result out of bounds");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pop) |=> s1_valid_reg)
        else $error("multiply stage dropped while output blocked");

endmodule

>>> rtl/gbk_glyph_address_stream.sv
// A byte that yields a result passes through the queue register, the multiply
// stage and the output register. Throughput: one byte per cycle while full is
// low, set by the single index-times-size multiplier stage; a 2-entry queue
// decouples byte classification from address generation.
// Reset: queue, stages and held lead byte cleared; config registers to defaults.
// Depends on gga_pkg, gga_front, gga_fifo, gga_back.
module gbk_glyph_address_stream
    import gga_pkg::*;
#(
    parameter int ADDR_BITS = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           text_byte,
    input  logic                 last_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           glyph_kind,
    output logic [ADDR_BITS-1:0] glyph_addr,
    output logic [9:0]           glyph_bytes,
    output logic [6:0]           glyph_width
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ASCII_BASE:  cfg_next.ascii_unit_base  = pwdata[BASE_W-1:0];
                REG_CJK_BASE:    cfg_next.cjk_unit_base    = pwdata[BASE_W-1:0];
                REG_GLYPH_SIZE:  cfg_next.glyph_size       = pwdata[SIZE_W-1:0];
                REG_ASCII_FIRST: cfg_next.ascii_first_code = pwdata[CODE_W-1:0];
                REG_INDEX_KIND:  cfg_next.index_kind       = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ASCII_BASE:  prdata = {{(PDATA_W-BASE_W){1'b0}}, cfg_reg.ascii_unit_base};
            REG_CJK_BASE:    prdata = {{(PDATA_W-BASE_W){1'b0}}, cfg_reg.cjk_unit_base};
            REG_GLYPH_SIZE:  prdata = {{(PDATA_W-SIZE_W){1'b0}}, cfg_reg.glyph_size};
            REG_ASCII_FIRST: prdata = {{(PDATA_W-CODE_W){1'b0}}, cfg_reg.ascii_first_code};
            REG_INDEX_KIND:  prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.index_kind};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ascii_unit_base  <= RST_ASCII_BASE;
            cfg_reg.cjk_unit_base    <= RST_CJK_BASE;
            cfg_reg.glyph_size       <= RST_GLYPH_SIZE;
            cfg_reg.ascii_first_code <= RST_ASCII_FIRST;
            cfg_reg.index_kind       <= RST_INDEX_KIND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gga_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    gga_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_head)
    );

    gga_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .glyph_kind  (glyph_kind),
        .glyph_addr  (glyph_addr),
        .glyph_bytes (glyph_bytes),
        .glyph_width (glyph_width)
    );

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for gbk_glyph_address_stream.
// Byte beats go in; fetch beats come out, checked against typed rows or a local decoder.
// Depends on gga_pkg and the gbk_glyph_address_stream RTL.
module tb_top
    import gga_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W = 25;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic [WIDTH_W-1:0] width;
    } glyph_req_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

    typedef struct packed {
        row_op_t    op;
        logic [7:0] code;
        logic       lst;
        logic [31:0] value;
        chk_t       chk;
        glyph_req_t want;
    } dir_row_t;

    localparam glyph_req_t NO_REQ = '{KIND_HALF, '0, '0, '0};

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 push;
    logic                 full;
    logic [7:0]           text_byte;
    logic                 last_byte;
    logic                 empty;
    logic                 pop;
    logic [1:0]           glyph_kind;
    logic [ADDR_W-1:0]    glyph_addr;
    logic [9:0]           glyph_bytes;
    logic [6:0]           glyph_width;

    // decoder copy of config and held lead
    logic [BASE_W-1:0] cfg_ascii_base;
    logic [BASE_W-1:0] cfg_cjk_base;
    logic [SIZE_W-1:0] cfg_size;
    logic [CODE_W-1:0] cfg_first;
    logic              cfg_index_kind;
    logic              held_lead;
    logic [7:0]        held_lead_byte;

    glyph_req_t pending_glyphs[$];
    int  errors = 0;
    int  glyphs_predicted = 0;
    bit  tx_burst = 0;
    bit  rx_burst = 0;
    int  rx_hold = 0;
    bit  bus_open = 0;

    dir_row_t dir_rows [29] = '{
        '{ROW_BYTE, 8'h20, 1'b0, 0, CHK_TYPED, '{KIND_HALF, 0, 16, 8}},
        '{ROW_BYTE, 8'h7F, 1'b0, 0, CHK_TYPED, '{KIND_HALF, 1520, 16, 8}},
        '{ROW_BYTE, 8'h0A, 1'b0, 0, CHK_TYPED, '{KIND_NEWLINE, 0, 0, 0}},
        '{ROW_BYTE, 8'h00, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h80, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h81, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h40, 1'b0, 0, CHK_TYPED, '{KIND_FULL, 0, 32, 16}},
        '{ROW_BYTE, 8'hFE, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'hFE, 1'b0, 0, CHK_TYPED, '{KIND_FULL, 766048, 32, 16}},
        '{ROW_BYTE, 8'h81, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h7F, 1'b0, 0, CHK_TYPED, '{KIND_HALF, 1520, 16, 8}},
        '{ROW_BYTE, 8'h81, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h0A, 1'b0, 0, CHK_TYPED, '{KIND_NEWLINE, 0, 0, 0}},
        '{ROW_BYTE, 8'hA1, 1'b1, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h81, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h41, 1'b1, 0, CHK_TYPED, '{KIND_FULL, 32, 32, 16}},
        '{ROW_REG, REG_ASCII_BASE, 1'b0, 32'hFFFFFF, CHK_NONE, NO_REQ},
        '{ROW_REG, REG_CJK_BASE, 1'b0, 32'hFFFFFF, CHK_NONE, NO_REQ},
        '{ROW_REG, REG_GLYPH_SIZE, 1'b0, 7, CHK_NONE, NO_REQ},
        '{ROW_REG, REG_ASCII_FIRST, 1'b0, 32'h41, CHK_NONE, NO_REQ},
        '{ROW_REG, REG_INDEX_KIND, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'h40, 1'b0, 0, CHK_TYPED, '{KIND_MISSING, 0, 0, 4}},
        '{ROW_BYTE, 8'h41, 1'b0, 0, CHK_TYPED, '{KIND_HALF, 24'hFFFFFF, 8, 4}},
        '{ROW_BYTE, 8'hA1, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'hA1, 1'b0, 0, CHK_TYPED, '{KIND_FULL, 24'hFFFFFF, 8, 8}},
        '{ROW_BYTE, 8'hA0, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'hA1, 1'b0, 0, CHK_TYPED, '{KIND_MISSING, 0, 0, 8}},
        '{ROW_BYTE, 8'hFE, 1'b0, 0, CHK_NONE, NO_REQ},
        '{ROW_BYTE, 8'hFE, 1'b0, 0, CHK_MODEL, NO_REQ}
    };

    gbk_glyph_address_stream #(
        .ADDR_BITS(ADDR_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .text_byte(text_byte),
        .last_byte(last_byte),
        .empty(empty),
        .pop(pop),
        .glyph_kind(glyph_kind),
        .glyph_addr(glyph_addr),
        .glyph_bytes(glyph_bytes),
        .glyph_width(glyph_width)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic bit is_trail(input logic [7:0] b);
        return b >= TRAIL_MIN && b <= TRAIL_MAX && b != TRAIL_GAP;
    endfunction

    // one text byte through the decoder; returns 1 when it yields a fetch beat
    function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                       output glyph_req_t r);
        int unsigned s;
        int unsigned w;
        int unsigned nb;
        int unsigned idx;
        longint unsigned a;
        bit hit;
        bit next_held;
        hit = 1'b0;
        next_held = 1'b0;
        r = NO_REQ;
        s = cfg_size;
        if (s < SIZE_MIN)
        begin
            s = SIZE_MIN;
        end
        if (s > SIZE_MAX)
        begin
            s = SIZE_MAX;
        end
        if (held_lead && is_trail(b))
        begin
            hit = 1'b1;
            nb = s * ((s + 7) / 8);
            if (!cfg_index_kind && (held_lead_byte < GB_FIRST || b < GB_FIRST))
            begin
                r.kind = KIND_MISSING;
                r.width = s[WIDTH_W-1:0];
            end
            else
            begin
                if (!cfg_index_kind)
                begin
                    idx = GB_ROW * (held_lead_byte - GB_FIRST) + (b - GB_FIRST);
                end
                else
                begin
                    idx = (held_lead_byte - LEAD_MIN) * GBK_ROW
                        + ((b >= TRAIL_SPLIT) ? b - TRAIL_HI_BASE : b - TRAIL_MIN);
                end
                a = cfg_cjk_base;
                a = a + idx * nb;
                r.kind = KIND_FULL;
                r.addr = a[ADDR_W-1:0];
                r.bytes = nb[BYTES_W-1:0];
                r.width = s[WIDTH_W-1:0];
            end
        end
        else if (b == CH_NEWLINE)
        begin
            hit = 1'b1;
            r.kind = KIND_NEWLINE;
        end
        else if (b >= HALF_MIN && b <= HALF_MAX)
        begin
            hit = 1'b1;
            w = s / 2;
            nb = s * ((w + 7) / 8);
            r.width = w[WIDTH_W-1:0];
            if (b < cfg_first)
            begin
                r.kind = KIND_MISSING;
            end
            else
            begin
                a = cfg_ascii_base;
                a = a + (b - cfg_first) * nb;
                r.kind = KIND_HALF;
                r.addr = a[ADDR_W-1:0];
                r.bytes = nb[BYTES_W-1:0];
            end
        end
        else if (b >= LEAD_MIN && b <= LEAD_MAX)
        begin
            next_held = 1'b1;
        end
        held_lead = next_held && !lst;
        held_lead_byte = held_lead ? b : 8'h00;
        return hit;
    endfunction

    function automatic int next_gap();
        return tx_burst ? 0 : $urandom_range(19, 0);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic lst, input chk_t chk,
                             input glyph_req_t typed);
        int gap;
        bit hit;
        glyph_req_t g;
        gap = next_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        text_byte <= b;
        last_byte <= lst;
        do @(posedge clk); while (full);
        hit = decode_byte(b, lst, g);
        if (hit)
        begin
            glyphs_predicted++;
        end
        if (chk == CHK_TYPED)
        begin
            pending_glyphs.push_back(typed);
        end
        else if (chk == CHK_MODEL && hit)
        begin
            pending_glyphs.push_back(g);
        end
        @(negedge clk);
    endtask

    task automatic send_text(input logic [7:0] b, input logic lst);
        send_byte(b, lst, CHK_MODEL, NO_REQ);
    endtask

    task automatic wait_results_done();
        push <= 1'b0;
        while (pending_glyphs.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // leaves psel high between back-to-back writes
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ASCII_BASE:  cfg_ascii_base = v[BASE_W-1:0];
            REG_CJK_BASE:    cfg_cjk_base = v[BASE_W-1:0];
            REG_GLYPH_SIZE:  cfg_size = v[SIZE_W-1:0];
            REG_ASCII_FIRST: cfg_first = v[CODE_W-1:0];
            REG_INDEX_KIND:  cfg_index_kind = v[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [31:0] ab, input logic [31:0] cb,
                              input logic [31:0] sz, input logic [31:0] fc,
                              input logic [31:0] ik);
        wait_results_done();
        write_reg(REG_ASCII_BASE, ab);
        write_reg(REG_CJK_BASE, cb);
        write_reg(REG_GLYPH_SIZE, sz);
        write_reg(REG_ASCII_FIRST, fc);
        write_reg(REG_INDEX_KIND, ik);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_lead();
        if (!cfg_index_kind && $urandom_range(3, 0) != 0)
        begin
            return 8'($urandom_range(LEAD_MAX, GB_FIRST));
        end
        return 8'($urandom_range(LEAD_MAX, LEAD_MIN));
    endfunction

    function automatic logic [7:0] pick_trail();
        case ($urandom_range(2, 0))
            0: return 8'($urandom_range(TRAIL_GAP - 1, TRAIL_MIN));
            1: return 8'($urandom_range(TRAIL_MAX, TRAIL_SPLIT));
            default: return 8'($urandom_range(TRAIL_MAX, GB_FIRST));
        endcase
    endfunction

    function automatic logic [7:0] pick_non_trail();
        case ($urandom_range(2, 0))
            0: return 8'($urandom_range(TRAIL_MIN - 1, 0));
            1: return TRAIL_GAP;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic rare_last();
        return $urandom_range(31, 0) == 0;
    endfunction

    task automatic run_text(input int glyphs_wanted);
        int start;
        int r;
        start = glyphs_predicted;
        while (glyphs_predicted - start < glyphs_wanted)
        begin
            r = $urandom_range(99, 0);
            if (r < 45)
            begin
                send_text(pick_lead(), 1'b0);
                send_text(pick_trail(), rare_last());
            end
            else if (r < 75)
            begin
                send_text(8'($urandom_range(HALF_MAX, HALF_MIN)), rare_last());
            end
            else if (r < 80)
            begin
                send_text(CH_NEWLINE, rare_last());
            end
            else if (r < 90)
            begin
                send_text(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
            end
            else if (r < 95)
            begin
                send_text(pick_lead(), 1'b0);
                send_text(pick_non_trail(), rare_last());
            end
            else
            begin
                send_text(pick_lead(), 1'b1);
            end
            if ($urandom_range(249, 0) == 0)
            begin
                wait_results_done();
            end
        end
    endtask

    function automatic logic [31:0] pick_size();
        if ($urandom_range(3, 0) == 0)
        begin
            return $urandom_range(127, 0);
        end
        return $urandom_range(SIZE_MAX, SIZE_MIN);
    endfunction

    initial
    begin : stimulus
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        text_byte = '0;
        last_byte = 1'b0;
        cfg_ascii_base = RST_ASCII_BASE;
        cfg_cjk_base = RST_CJK_BASE;
        cfg_size = RST_GLYPH_SIZE;
        cfg_first = RST_ASCII_FIRST;
        cfg_index_kind = RST_INDEX_KIND;
        held_lead = 1'b0;
        held_lead_byte = 8'h00;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_REG)
            begin
                if (!bus_open)
                begin
                    wait_results_done();
                    bus_open = 1'b1;
                end
                write_reg(dir_rows[i].code[REG_IDX_W-1:0], dir_rows[i].value);
            end
            else
            begin
                if (bus_open)
                begin
                    psel <= 1'b0;
                    penable <= 1'b0;
                    bus_open = 1'b0;
                end
                send_byte(dir_rows[i].code, dir_rows[i].lst, dir_rows[i].chk,
                          dir_rows[i].want);
            end
        end

        for (int p = 0; p < 8; p++)
        begin
            tx_burst = (p == 1 || p == 2 || p == 6);
            rx_burst = (p == 3 || p == 6);
            case (p)
                0: set_config(0, 0, SIZE_MAX, 0, 1);
                1: set_config(32'hFFFFFF, 32'hFFFFFF, SIZE_MIN, 127, 0);
                2: set_config($urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF, 65, 32, 0);
                3: set_config($urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF, 0, 16, 1);
                4: set_config(32'hFFFFFF, 0, 127, $urandom_range(127, 0), 1);
                default: set_config($urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
                                    pick_size(), $urandom_range(127, 0),
                                    $urandom_range(1, 0));
            endcase
            if (p == 2)
            begin
                rx_hold = 400;
            end
            run_text(145);
        end

        wait_results_done();
        repeat (6) @(negedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    task automatic flag_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        errors++;
        $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    endtask

    initial
    begin : result_sink
        int wait_cycles;
        glyph_req_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                wait_cycles = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                wait_cycles = rx_burst ? 0 : $urandom_range(19, 0);
            end
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (pending_glyphs.size() == 0)
            begin
                errors++;
                $display("%0t beat with none expected: kind %0d addr %0h bytes %0d width %0d",
                         $time, glyph_kind, glyph_addr, glyph_bytes, glyph_width);
            end
            else
            begin
                want = pending_glyphs.pop_front();
                if (glyph_kind !== want.kind)
                begin
                    flag_field("glyph_kind", want.kind, glyph_kind);
                end
                if (glyph_addr !== want.addr)
                begin
                    flag_field("glyph_addr", want.addr, glyph_addr);
                end
                if (glyph_bytes !== want.bytes)
                begin
                    flag_field("glyph_bytes", want.bytes, glyph_bytes);
                end
                if (glyph_width !== want.width)
                begin
                    flag_field("glyph_width", want.width, glyph_width);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/gga_pkg.sv
rtl/gga_front.sv
rtl/gga_fifo.sv
rtl/gga_back.sv
rtl/gbk_glyph_address_stream.sv
tb/sv/tb_top.sv
